// ----- hw/rtl/bmhq_pkg.sv -----
// Shared types and constants for the binary min-heap priority queue.
// Used by the channel interfaces, the compare unit and the top level.
// No dependencies.
package bmhq_pkg;

	// Heap sizing
	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// Child index arithmetic needs room for 2*i+2 beyond the address range
	localparam int IDX_W    = ADDR_W + 2;

	// Field widths
	localparam int OP_W    = 2;
	localparam int VAL_W   = 16;
	localparam int PRI_W   = 32;
	localparam int COUNT_W = 9;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// One stored heap entry
	typedef struct packed {
		logic        [VAL_W-1:0] val;
		logic signed [PRI_W-1:0] pri;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One result transfer
	typedef struct packed {
		logic        [VAL_W-1:0]   top_value;
		logic signed [PRI_W-1:0]   top_priority;
		logic        [COUNT_W-1:0] entry_count;
		logic                      is_empty;
		logic                      overflow;
	} result_t;

endpackage

// ----- hw/rtl/bmhq_req_if.sv -----
// Request channel: operation code and the pair carried by a push.
// Depends on bmhq_pkg.
interface bmhq_req_if import bmhq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic        [OP_W-1:0]  operation;
	logic        [VAL_W-1:0] item_value;
	logic signed [PRI_W-1:0] item_priority;

	modport source (output valid, output operation, output item_value,
		output item_priority, input ready);
	modport sink (input valid, input operation, input item_value,
		input item_priority, output ready);
endinterface

// ----- hw/rtl/bmhq_rsp_if.sv -----
// Response channel: top pair, entry count and flags after each operation.
// Depends on bmhq_pkg.
interface bmhq_rsp_if import bmhq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic        [VAL_W-1:0]   top_value;
	logic signed [PRI_W-1:0]   top_priority;
	logic        [COUNT_W-1:0] entry_count;
	logic                      is_empty;
	logic                      overflow;

	modport source (output valid, output top_value, output top_priority,
		output entry_count, output is_empty, output overflow, input ready);
	modport sink (input valid, input top_value, input top_priority,
		input entry_count, input is_empty, input overflow, output ready);
endinterface

// ----- hw/rtl/bmhq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bmhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- hw/rtl/bmhq_cmp.sv -----
// Shared priority comparator: signed less-than on two priority keys.
// Depends on bmhq_pkg.
module bmhq_cmp import bmhq_pkg::*; (
	input  logic signed [PRI_W-1:0] a,
	input  logic signed [PRI_W-1:0] b,
	output logic                    lt
);

	// Strict signed order; ties are not less
	assign lt = (a < b);

endmodule

// ----- hw/rtl/binary_min_heap_queue_top.sv -----
// Binary min-heap priority queue top level: sequencer, heap RAM and compare unit.
// Depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if, bmhq_ram and bmhq_cmp.
//
// Holds up to CAPACITY (value, priority) pairs in one RAM and serves the smallest
// priority first. Each request is a push, a pop or a clear and yields exactly one
// response with the top pair, the count and an overflow flag for a dropped push.
// One request is worked at a time; ready is high only while the sequencer is idle.
// The moving entry is held in a register while the hole walks the tree: a push
// climbs one level per parent compare, and a pop descends by reading the left
// child and then, at a node with two children, the right child, since the RAM
// read port delivers one child per cycle. Clear, a dropped push and a pop that
// finds the heap empty or takes its last entry skip the walk. A finished response
// waits in an output register until taken; the sequencer waits in its last state
// only while an earlier response still occupies that register.
module binary_min_heap_queue_top import bmhq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	bmhq_req_if.sink        req,
	bmhq_rsp_if.source      rsp
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_UP,
		S_LAST,
		S_DN_L,
		S_DN_R,
		S_FIN,
		S_DONE
	} state_t;

	state_t                state_q, state_d;
	logic [OP_W-1:0]       op_q, op_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [ADDR_W-1:0]     hole_q, hole_d;
	logic [ADDR_W-1:0]     par_q, par_d;
	logic [ADDR_W-1:0]     lc_q, lc_d;
	entry_t                item_q, item_d;
	entry_t                best_q, best_d;
	logic                  best_child_q, best_child_d;
	logic                  ovf_q, ovf_d;
	entry_t                top_q;
	result_t               res_q;
	logic                  out_valid_q;

	// RAM and compare unit hookup
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	entry_t                wr_data;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ENTRY_W-1:0]    rd_data;
	entry_t                rd_entry;
	logic signed [PRI_W-1:0] cmp_a, cmp_b;
	logic                  cmp_lt;

	// Sift-down step toward a child
	logic                  mv;
	entry_t                mv_e;
	logic [ADDR_W-1:0]     mv_idx;
	logic [IDX_W-1:0]      nlc_w;
	logic [IDX_W-1:0]      rc_w;
	logic [IDX_W-1:0]      cnt_w;
	logic                  out_load;

	assign rd_entry = entry_t'(rd_data);
	assign rc_w     = IDX_W'(lc_q) + IDX_W'(1);
	assign cnt_w    = IDX_W'(cnt_q);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	bmhq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (ENTRY_W'(wr_data)),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Steer the comparator: climbing compares the item against the parent,
	// descending compares the left child against the item, then the right
	// child against the better of the two
	always_comb begin
		if (state_q == S_UP) begin
			cmp_a = item_q.pri;
			cmp_b = rd_entry.pri;
		end else if (state_q == S_DN_R) begin
			cmp_a = rd_entry.pri;
			cmp_b = best_q.pri;
		end else begin
			cmp_a = rd_entry.pri;
			cmp_b = item_q.pri;
		end
	end

	bmhq_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (cmp_lt)
	);

	// Sequencer next-state logic
	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		cnt_d        = cnt_q;
		hole_d       = hole_q;
		par_d        = par_q;
		lc_d         = lc_q;
		item_d       = item_q;
		best_d       = best_q;
		best_child_d = best_child_q;
		ovf_d        = ovf_q;
		wr_en        = 1'b0;
		wr_addr      = hole_q;
		wr_data      = item_q;
		rd_addr      = par_q;
		mv           = 1'b0;
		mv_e         = rd_entry;
		mv_idx       = lc_q;
		nlc_w        = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_d       = req.operation;
					item_d.val = req.item_value;
					item_d.pri = req.item_priority;
					ovf_d      = 1'b0;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_PUSH: begin
						if (cnt_q >= CNT_W'(CAPACITY)) begin
							ovf_d   = 1'b1;
							state_d = S_DONE;
						end else begin
							cnt_d  = cnt_q + CNT_W'(1);
							hole_d = ADDR_W'(cnt_q);
							if (cnt_q == '0) begin
								state_d = S_FIN;
							end else begin
								rd_addr = ADDR_W'((cnt_q - CNT_W'(1)) >> 1);
								par_d   = rd_addr;
								state_d = S_UP;
							end
						end
					end
					OP_POP: begin
						if (cnt_q == '0) begin
							state_d = S_DONE;
						end else begin
							cnt_d = cnt_q - CNT_W'(1);
							if (cnt_q == CNT_W'(1)) begin
								state_d = S_DONE;
							end else begin
								// fetch the last entry
								rd_addr = ADDR_W'(cnt_q - CNT_W'(1));
								state_d = S_LAST;
							end
						end
					end
					OP_CLEAR: begin
						cnt_d   = '0;
						state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_UP: begin
				if (cmp_lt) begin
					// pull the parent down into the hole
					wr_en   = 1'b1;
					wr_data = rd_entry;
					hole_d  = par_q;
					if (par_q == '0) begin
						state_d = S_FIN;
					end else begin
						rd_addr = (par_q - ADDR_W'(1)) >> 1;
						par_d   = rd_addr;
					end
				end else begin
					wr_en   = 1'b1;
					state_d = S_DONE;
				end
			end
			S_LAST: begin
				item_d = rd_entry;
				hole_d = '0;
				if (cnt_q <= CNT_W'(1)) begin
					state_d = S_FIN;
				end else begin
					rd_addr = ADDR_W'(1);
					lc_d    = ADDR_W'(1);
					state_d = S_DN_L;
				end
			end
			S_DN_L: begin
				if (rc_w < cnt_w) begin
					best_d       = cmp_lt ? rd_entry : item_q;
					best_child_d = cmp_lt;
					rd_addr      = ADDR_W'(rc_w);
					state_d      = S_DN_R;
				end else if (cmp_lt) begin
					mv     = 1'b1;
					mv_e   = rd_entry;
					mv_idx = lc_q;
				end else begin
					wr_en   = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DN_R: begin
				if (cmp_lt) begin
					mv     = 1'b1;
					mv_e   = rd_entry;
					mv_idx = ADDR_W'(rc_w);
				end else if (best_child_q) begin
					mv     = 1'b1;
					mv_e   = best_q;
					mv_idx = lc_q;
				end else begin
					wr_en   = 1'b1;
					state_d = S_DONE;
				end
			end
			S_FIN: begin
				wr_en   = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Move the chosen child up and descend one level
		if (mv) begin
			wr_en   = 1'b1;
			wr_data = mv_e;
			hole_d  = mv_idx;
			nlc_w   = {1'b0, mv_idx, 1'b1};
			if (nlc_w >= cnt_w) begin
				state_d = S_FIN;
			end else begin
				rd_addr = ADDR_W'(nlc_w);
				lc_d    = ADDR_W'(nlc_w);
				state_d = S_DN_L;
			end
		end
	end

	// State, working registers and the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			cnt_q        <= '0;
			hole_q       <= '0;
			par_q        <= '0;
			lc_q         <= '0;
			item_q       <= '0;
			best_q       <= '0;
			best_child_q <= 1'b0;
			ovf_q        <= 1'b0;
			top_q        <= '0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			op_q         <= op_d;
			cnt_q        <= cnt_d;
			hole_q       <= hole_d;
			par_q        <= par_d;
			lc_q         <= lc_d;
			item_q       <= item_d;
			best_q       <= best_d;
			best_child_q <= best_child_d;
			ovf_q        <= ovf_d;
			// shadow the root entry
			if (wr_en && (wr_addr == '0)) begin
				top_q <= wr_data;
			end
			// hold the response until the transfer completes
			if (out_load) begin
				res_q.top_value    <= (cnt_q == '0) ? '0 : top_q.val;
				res_q.top_priority <= (cnt_q == '0) ? '0 : top_q.pri;
				res_q.entry_count  <= COUNT_W'(cnt_q);
				res_q.is_empty     <= (cnt_q == '0);
				res_q.overflow     <= ovf_q;
				out_valid_q        <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.top_value    = res_q.top_value;
	assign rsp.top_priority = res_q.top_priority;
	assign rsp.entry_count  = res_q.entry_count;
	assign rsp.is_empty     = res_q.is_empty;
	assign rsp.overflow     = res_q.overflow;

endmodule
